// ----- src/jtsm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtsm_pkg
// Types and constants shared by the joystick to serial mouse packet encoder.
// ----------------------------------------------------------------------------
package jtsm_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned MarginW = 7;
  localparam int unsigned PktLen  = 3;
  localparam int unsigned CntW    = 2;

  localparam logic [MarginW-1:0] MarginRst = 7'd15;
  localparam logic [ByteW-1:0]   KeyRst    = 8'h17;
  localparam logic [ByteW-1:0]   AxisMid   = 8'd127;
  localparam logic [ByteW-1:0]   AxisTop   = 8'd255;

  // Packet bit patterns.
  localparam logic [ByteW-1:0] SyncBit  = 8'h80;
  localparam logic [ByteW-1:0] HeadBit  = 8'b0100_0000;
  localparam logic [ByteW-1:0] LeftMsk  = 8'h01;
  localparam logic [ByteW-1:0] RightMsk = 8'h02;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_CLIP_MARGIN = 1'b0,
    CFG_DECRYPT_KEY = 1'b1
  } cfg_idx_e;

  // Result of processing one report.
  typedef struct packed {
    logic             emit;
    logic [ByteW-1:0] cx;
    logic [ByteW-1:0] cy;
    logic             left;
    logic             right;
    logic [ByteW-1:0] byte0;
    logic [ByteW-1:0] byte1;
    logic [ByteW-1:0] byte2;
  } enc_res_t;

  // Calibration and button history.
  typedef struct packed {
    logic             calibrated;
    logic [ByteW-1:0] offset_x;
    logic [ByteW-1:0] offset_y;
    logic             prev_left;
    logic             prev_right;
  } enc_state_t;

endpackage

// ----- src/jtsm_chan_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtsm_chan_if
// Valid/ready channels for joystick reports and mouse packet bytes.
// ----------------------------------------------------------------------------
interface jtsm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_stick_x;
  logic [7:0] raw_stick_y;
  logic [7:0] raw_button_byte;

  modport source (output valid, raw_stick_x, raw_stick_y, raw_button_byte, input ready);
  modport sink   (input valid, raw_stick_x, raw_stick_y, raw_button_byte, output ready);
endinterface

interface jtsm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       last_of_packet;

  modport source (output valid, packet_byte, last_of_packet, input ready);
  modport sink   (input valid, packet_byte, last_of_packet, output ready);
endinterface

// ----- src/jtsm_encode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtsm_encode
// Decrypts, clips and centers one report and forms its three packet bytes.
// ----------------------------------------------------------------------------
module jtsm_encode (
  input  logic [7:0]          raw_x_i,
  input  logic [7:0]          raw_y_i,
  input  logic [7:0]          raw_btn_i,
  input  logic [6:0]          margin_i,
  input  logic [7:0]          key_i,
  input  jtsm_pkg::enc_state_t state_i,
  output jtsm_pkg::enc_res_t   res_o
);
  import jtsm_pkg::*;

  logic [ByteW-1:0] dx, dy, db, hi, lo, clx, cly, difx, dify, qx, qy;
  logic [ByteW-1:0] head;
  logic             left, right;

  function automatic logic [ByteW-1:0] clip(input logic [ByteW-1:0] v,
                                            input logic [ByteW-1:0] top,
                                            input logic [ByteW-1:0] bot);
    logic [ByteW-1:0] t;
    t = (v > top) ? top : v;
    return (t < bot) ? bot : t;
  endfunction

  // Signed divide by 8 rounding toward zero: bias negatives by 7, then shift.
  function automatic logic [ByteW-1:0] div8(input logic [ByteW-1:0] v);
    logic [ByteW-1:0] b;
    b = v + (v[ByteW-1] ? 8'd7 : 8'd0);
    return ByteW'($signed(b) >>> 3);
  endfunction

  always_comb begin
    dx   = (raw_x_i ^ key_i) + key_i;
    dy   = (raw_y_i ^ key_i) + key_i;
    db   = (raw_btn_i ^ key_i) + key_i;
    lo   = {1'b0, margin_i};
    hi   = AxisTop - lo;
    clx  = clip(dx, hi, lo);
    cly  = clip(dy, hi, lo);
    res_o.cx = clx - AxisMid;
    res_o.cy = AxisMid - cly;
    difx = res_o.cx - state_i.offset_x;
    dify = res_o.cy - state_i.offset_y;
    qx   = div8(difx);
    qy   = div8(dify);
    left  = (db & LeftMsk) == '0;
    right = (db & RightMsk) == '0;
    res_o.left  = left;
    res_o.right = right;
    res_o.emit  = state_i.calibrated &&
                  ((left != state_i.prev_left) || (right != state_i.prev_right) ||
                   (qx != '0) || (qy != '0));
    head = HeadBit | SyncBit;
    head[5] = right;
    head[4] = left;
    head[3] = qy[7];
    head[2] = qy[6];
    head[1] = qx[7];
    head[0] = qx[6];
    res_o.byte0 = head;
    res_o.byte1 = SyncBit | {2'b00, qx[5:0]};
    res_o.byte2 = SyncBit | {2'b00, qy[5:0]};
  end

endmodule

// ----- src/joystick_to_serial_mouse_packets_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_to_serial_mouse_packets_unit
// Turns joystick reports into three-byte serial mouse packets.
// ----------------------------------------------------------------------------
//  Channel   Dir  Carries
//  in_chan   in   one joystick report: raw X, Y and button bytes
//  out_chan  out  one packet byte, last_of_packet on the third
//  cfg_*     in   register writes: 0 clip margin, 1 decrypt key
//
// A report waits in the input register, then is encoded in a single
// pass into the three-byte packet buffer, which sends one byte per cycle
// while out_chan.ready is high. A new report is taken while the last packet
// byte is being sent.
// Reset clears calibration, button history and both stages; no clearing pass.
// ----------------------------------------------------------------------------
module joystick_to_serial_mouse_packets_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  jtsm_in_if.sink     in_chan,
  jtsm_out_if.source  out_chan
);
  import jtsm_pkg::*;

  logic [MarginW-1:0] margin_q;
  logic [ByteW-1:0]   key_q;
  logic               s1_valid_q;
  logic [ByteW-1:0]   s1_x_q, s1_y_q, s1_b_q;
  enc_state_t         st_q, st_d;
  enc_res_t           res;
  logic [ByteW-1:0]   pkt_q [PktLen];
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               in_acc, out_acc, pkt_free, s1_adv, load;

  jtsm_encode u_encode (
    .raw_x_i  (s1_x_q),
    .raw_y_i  (s1_y_q),
    .raw_btn_i(s1_b_q),
    .margin_i (margin_q),
    .key_i    (key_q),
    .state_i  (st_q),
    .res_o    (res)
  );

  assign out_acc  = out_chan.valid && out_chan.ready;
  assign pkt_free = (cnt_q == '0) || ((cnt_q == CntW'(1)) && out_acc);
  assign s1_adv   = s1_valid_q && pkt_free;
  assign load     = s1_adv && res.emit;
  assign in_chan.ready = !s1_valid_q || s1_adv;
  assign in_acc   = in_chan.valid && in_chan.ready;

  assign out_chan.valid          = cnt_q != '0;
  assign out_chan.packet_byte    = pkt_q[0];
  assign out_chan.last_of_packet = cnt_q == CntW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= MarginRst;
      key_q    <= KeyRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CLIP_MARGIN: margin_q <= cfg_data_i[MarginW-1:0];
        CFG_DECRYPT_KEY: key_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_q <= in_chan.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_x_q <= in_chan.raw_stick_x;
      s1_y_q <= in_chan.raw_stick_y;
      s1_b_q <= in_chan.raw_button_byte;
    end
  end

  // The first report only records offsets; later ones update button history
  // when they produce a packet.
  always_comb begin
    st_d = st_q;
    if (s1_adv) begin
      if (!st_q.calibrated) begin
        st_d.calibrated = 1'b1;
        st_d.offset_x   = res.cx;
        st_d.offset_y   = res.cy;
      end else if (res.emit) begin
        st_d.prev_left  = res.left;
        st_d.prev_right = res.right;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (load) begin
      cnt_d = CntW'(PktLen);
    end else if (out_acc) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pkt_q[0] <= res.byte0;
      pkt_q[1] <= res.byte1;
      pkt_q[2] <= res.byte2;
    end else if (out_acc) begin
      pkt_q[0] <= pkt_q[1];
      pkt_q[1] <= pkt_q[2];
      pkt_q[2] <= pkt_q[2];
    end
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3 || !out_chan.last_of_packet)
    else $error("packet count and last flag disagree");

  a_calibrate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && !st_q.calibrated) |=> (st_q.calibrated && cnt_q == $past(cnt_d)))
    else $error("calibration report did not set calibrated");

  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (cnt_q == '0 || (cnt_q == CntW'(1) && out_acc)))
    else $error("packet loaded over unsent bytes");

  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_chan.last_of_packet && !load) |=> !out_chan.valid)
    else $error("output still valid after last byte");
`endif

endmodule
